// ===== sv/pcsd_pkg.sv =====
// Shared constants, field layout and controller/datapath interface types of the decoder.
`default_nettype none

package pcsd_pkg;

  // Sizing of the code table and the bit accumulator.
  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int BYTE_BITS     = 8;

  localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCAN_CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ACC_W       = MAX_CODE_LEN;
  localparam int ACC_LEN_W   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN + 1) : 1;
  localparam int LEN_SEEN_N  = 1 << ACC_LEN_W;

  // Input field widths.
  localparam int OP_W          = 2;
  localparam int ENTRY_INDEX_W = 8;
  localparam int CODE_VALUE_W  = 32;
  localparam int CODE_LENGTH_W = 6;
  localparam int SYMBOL_W      = 8;
  localparam int DATA_BYTE_W   = 8;
  localparam int VALID_BITS_W  = 4;

  localparam int LEN_CMP_W = (ACC_LEN_W > CODE_LENGTH_W) ? ACC_LEN_W : CODE_LENGTH_W;
  localparam int IDX_CMP_W = ENTRY_INDEX_W + 1;

  // Input tdata layout, lowest field first.
  localparam int IN_IDX_LO   = 0;
  localparam int IN_CODE_LO  = IN_IDX_LO + ENTRY_INDEX_W;
  localparam int IN_LEN_LO   = IN_CODE_LO + CODE_VALUE_W;
  localparam int IN_SYM_LO   = IN_LEN_LO + CODE_LENGTH_W;
  localparam int IN_BYTE_LO  = IN_SYM_LO + SYMBOL_W;
  localparam int IN_VBITS_LO = IN_BYTE_LO + DATA_BYTE_W;
  localparam int IN_USED_W   = IN_VBITS_LO + VALID_BITS_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  localparam logic [ACC_LEN_W-1:0]    MAX_LEN_L     = ACC_LEN_W'(MAX_CODE_LEN);
  localparam logic [LEN_CMP_W-1:0]    MAX_LEN_CMP   = LEN_CMP_W'(MAX_CODE_LEN);
  localparam logic [IDX_CMP_W-1:0]    ENTRIES_CMP   = IDX_CMP_W'(TABLE_ENTRIES);
  localparam logic [SCAN_CNT_W-1:0]   ENTRIES_CNT   = SCAN_CNT_W'(TABLE_ENTRIES);
  localparam logic [VALID_BITS_W-1:0] BYTE_BITS_L   = VALID_BITS_W'(BYTE_BITS);

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // Result kinds.
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  typedef struct packed {
    logic [CODE_VALUE_W-1:0]  code;
    logic [CODE_LENGTH_W-1:0] len;
    logic [SYMBOL_W-1:0]      sym;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic tbl_write;
    logic acc_clear;
    logic data_load;
    logic bit_append;
    logic emit_err;
    logic emit_hit;
    logic scan_start;
    logic scan_run;
    logic flush;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0]      in_op;
    logic                 in_nbits_zero;
    logic                 acc_full;
    logic                 len_seen_next;
    logic                 last_bit;
    logic                 bits_left_zero;
    logic                 match;
    logic                 scan_done;
    logic                 can_emit;
    logic                 pend_valid;
    logic                 out_free;
    logic [ACC_LEN_W-1:0] acc_len;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/pcsd_ctrl.sv =====
// Sequencing state machine of the decoder: item intake, per-bit steps, table scan, result flush.
`default_nettype none

module pcsd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire pcsd_pkg::stat_t st,
  output pcsd_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BIT   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_HIT   = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_tvalid) begin
          case (st.in_op)
            pcsd_pkg::OP_LOAD: begin
              cmd.tbl_write = 1'b1;
            end
            pcsd_pkg::OP_START: begin
              cmd.acc_clear = 1'b1;
            end
            pcsd_pkg::OP_DATA: begin
              if (!st.in_nbits_zero) begin
                cmd.data_load = 1'b1;
                state_nxt     = ST_BIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BIT: begin
        if (st.acc_full) begin
          // The bit would overflow the accumulator: report it and drop the bit.
          if (st.can_emit) begin
            cmd.emit_err = 1'b1;
            state_nxt    = st.last_bit ? ST_FLUSH : ST_BIT;
          end
        end else begin
          cmd.bit_append = 1'b1;
          if (st.len_seen_next) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = st.last_bit ? ST_FLUSH : ST_BIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.match) begin
          state_nxt = ST_HIT;
        end else if (st.scan_done) begin
          state_nxt = st.bits_left_zero ? ST_FLUSH : ST_BIT;
        end
      end
      ST_HIT: begin
        if (st.can_emit) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = st.bits_left_zero ? ST_FLUSH : ST_BIT;
        end
      end
      ST_FLUSH: begin
        if (!st.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pcsd_dp.sv =====
// Datapath of the decoder: code table memory, accumulator, scan pipeline and result registers.
`default_nettype none

module pcsd_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [pcsd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [pcsd_pkg::OP_W-1:0]         in_op,
  input  wire pcsd_pkg::cmd_t                    cmd,
  output pcsd_pkg::stat_t                        st,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [pcsd_pkg::SYMBOL_W-1:0]          out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast
);

  // Input field decode.
  logic [pcsd_pkg::ENTRY_INDEX_W-1:0] in_idx;
  logic [pcsd_pkg::CODE_VALUE_W-1:0]  in_code;
  logic [pcsd_pkg::CODE_LENGTH_W-1:0] in_len;
  logic [pcsd_pkg::SYMBOL_W-1:0]      in_sym;
  logic [pcsd_pkg::DATA_BYTE_W-1:0]   in_byte;
  logic [pcsd_pkg::VALID_BITS_W-1:0]  in_vbits;
  logic                               idx_ok;
  logic [pcsd_pkg::IDX_W-1:0]         wr_addr;

  assign in_idx   = in_tdata[pcsd_pkg::IN_IDX_LO   +: pcsd_pkg::ENTRY_INDEX_W];
  assign in_code  = in_tdata[pcsd_pkg::IN_CODE_LO  +: pcsd_pkg::CODE_VALUE_W];
  assign in_len   = in_tdata[pcsd_pkg::IN_LEN_LO   +: pcsd_pkg::CODE_LENGTH_W];
  assign in_sym   = in_tdata[pcsd_pkg::IN_SYM_LO   +: pcsd_pkg::SYMBOL_W];
  assign in_byte  = in_tdata[pcsd_pkg::IN_BYTE_LO  +: pcsd_pkg::DATA_BYTE_W];
  assign in_vbits = in_tdata[pcsd_pkg::IN_VBITS_LO +: pcsd_pkg::VALID_BITS_W];
  assign idx_ok   = {1'b0, in_idx} < pcsd_pkg::ENTRIES_CMP;
  assign wr_addr  = in_idx[pcsd_pkg::IDX_W-1:0];

  // Code table. Entries carry a written flag; an unwritten entry never matches.
  pcsd_pkg::entry_t                     mem [pcsd_pkg::TABLE_ENTRIES];
  logic [pcsd_pkg::TABLE_ENTRIES-1:0]   ent_valid_r;
  logic [pcsd_pkg::LEN_SEEN_N-1:0]      len_seen_r;
  logic                                 tbl_we;
  logic                                 len_in_range;

  assign tbl_we       = cmd.tbl_write && idx_ok;
  assign len_in_range = (in_len != '0) &&
                        (pcsd_pkg::LEN_CMP_W'(in_len) <= pcsd_pkg::MAX_LEN_CMP);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[wr_addr] <= '{code: in_code, len: in_len, sym: in_sym};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      len_seen_r  <= '0;
    end else if (tbl_we) begin
      ent_valid_r[wr_addr] <= 1'b1;
      // Lengths only ever get marked; a stale mark merely costs a scan.
      if (len_in_range) begin
        len_seen_r[pcsd_pkg::ACC_LEN_W'(in_len)] <= 1'b1;
      end
    end
  end

  // Current data byte.
  logic [pcsd_pkg::DATA_BYTE_W-1:0]  byte_r;
  logic [pcsd_pkg::VALID_BITS_W-1:0] bits_left_r;
  logic                              consume;

  assign consume = cmd.bit_append || cmd.emit_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r <= '0;
    end else if (cmd.data_load) begin
      bits_left_r <= (in_vbits > pcsd_pkg::BYTE_BITS_L) ? pcsd_pkg::BYTE_BITS_L : in_vbits;
    end else if (consume) begin
      bits_left_r <= pcsd_pkg::VALID_BITS_W'(bits_left_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_load) begin
      byte_r <= in_byte;
    end else if (consume) begin
      byte_r <= byte_r >> 1;
    end
  end

  // Bit accumulator. The mask has one set bit per accumulated bit.
  logic [pcsd_pkg::ACC_W-1:0]     acc_bits_r;
  logic [pcsd_pkg::ACC_W-1:0]     acc_mask_r;
  logic [pcsd_pkg::ACC_LEN_W-1:0] acc_len_r;
  logic [pcsd_pkg::ACC_W-1:0]     acc_mask_nxt;
  logic [pcsd_pkg::ACC_LEN_W-1:0] acc_len_nxt;
  logic                           acc_clr;

  assign acc_mask_nxt = (acc_mask_r << 1) | pcsd_pkg::ACC_W'(1);
  assign acc_len_nxt  = pcsd_pkg::ACC_LEN_W'(acc_len_r + 1'b1);
  assign acc_clr      = cmd.acc_clear || cmd.emit_err || cmd.emit_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bits_r <= '0;
      acc_mask_r <= '0;
      acc_len_r  <= '0;
    end else if (acc_clr) begin
      acc_bits_r <= '0;
      acc_mask_r <= '0;
      acc_len_r  <= '0;
    end else if (cmd.bit_append) begin
      acc_bits_r <= acc_bits_r | ((acc_mask_nxt ^ acc_mask_r) & {pcsd_pkg::ACC_W{byte_r[0]}});
      acc_mask_r <= acc_mask_nxt;
      acc_len_r  <= acc_len_nxt;
    end
  end

  // Table scan: one read issued per cycle, its registered result compared in the next cycle.
  logic [pcsd_pkg::SCAN_CNT_W-1:0] scan_cnt_r;
  logic                            rd_vld_r;
  logic                            scan_end;
  logic [pcsd_pkg::IDX_W-1:0]      rd_addr;
  pcsd_pkg::entry_t                rd_q_r;
  logic                            rd_ent_valid_r;
  logic                            match;
  logic [pcsd_pkg::SYMBOL_W-1:0]   hit_sym_r;

  assign scan_end = (scan_cnt_r == pcsd_pkg::ENTRIES_CNT);
  assign rd_addr  = scan_cnt_r[pcsd_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld_r <= !scan_end;
      if (!scan_end) begin
        scan_cnt_r <= pcsd_pkg::SCAN_CNT_W'(scan_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r         <= mem[rd_addr];
    rd_ent_valid_r <= ent_valid_r[rd_addr];
  end

  assign match = rd_vld_r && rd_ent_valid_r && (rd_q_r.len != '0) &&
                 (pcsd_pkg::LEN_CMP_W'(rd_q_r.len) == pcsd_pkg::LEN_CMP_W'(acc_len_r)) &&
                 ((pcsd_pkg::ACC_W'(rd_q_r.code) & acc_mask_r) == acc_bits_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_run && match) begin
      hit_sym_r <= rd_q_r.sym;
    end
  end

  // Results: a pending stage holds the newest result until it is known whether it is
  // the final one of the item, then it moves to the output register.
  logic                          pend_valid_r;
  logic                          pend_kind_r;
  logic [pcsd_pkg::SYMBOL_W-1:0] pend_sym_r;
  logic                          out_valid_r;
  logic                          out_kind_r;
  logic                          out_last_r;
  logic [pcsd_pkg::SYMBOL_W-1:0] out_sym_r;
  logic                          out_free;
  logic                          emit;
  logic                          push;

  assign out_free = !out_valid_r || out_tready;
  assign emit     = cmd.emit_err || cmd.emit_hit;
  assign push     = (emit && pend_valid_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_kind_r <= cmd.emit_err ? pcsd_pkg::KIND_ERROR : pcsd_pkg::KIND_SYMBOL;
      pend_sym_r  <= cmd.emit_err ? '0 : hit_sym_r;
    end
    if (push) begin
      out_kind_r <= pend_kind_r;
      out_sym_r  <= pend_sym_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Status toward the controller.
  always_comb begin
    st                = '0;
    st.in_op          = in_op;
    st.in_nbits_zero  = (in_vbits == '0);
    st.acc_full       = (acc_len_r >= pcsd_pkg::MAX_LEN_L);
    st.len_seen_next  = len_seen_r[acc_len_nxt];
    st.last_bit       = (bits_left_r == pcsd_pkg::VALID_BITS_W'(1));
    st.bits_left_zero = (bits_left_r == '0);
    st.match          = match;
    st.scan_done      = !rd_vld_r && scan_end;
    st.can_emit       = !pend_valid_r || out_free;
    st.pend_valid     = pend_valid_r;
    st.out_free       = out_free;
    st.acc_len        = acc_len_r;
  end

endmodule

`default_nettype wire

// ===== sv/prefix_code_stream_decoder.sv =====
// Top level of the prefix-code stream decoder: controller, datapath and checks.
// Load and start requests are taken in the idle state. A data request is accepted, then its
// bits are consumed one by one, with a table scan after each bit whose new length equals any
// length ever loaded (a hit ends the scan and is then emitted), and the request ends in the
// flush state. The scan reads the table entries in order through its single read port.
// Synchronous active-low reset clears control state, entry written flags, length marks and
// the accumulator; table memory contents are not cleared.
`default_nettype none

module prefix_code_stream_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input requests.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata, from bit 0: entry_index[7:0], code_value[39:8], code_length[45:40],
  // entry_symbol[53:46], data_byte[61:54], valid_bits[65:62], zero fill [71:66].
  input  wire logic [pcsd_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: op[1:0] (load entry, decode data byte, start stream).
  input  wire logic [pcsd_pkg::OP_W-1:0]       in_tuser,
  // Results.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: out_symbol[7:0].
  output logic [pcsd_pkg::SYMBOL_W-1:0]        out_tdata,
  // out_tuser: kind (0 decoded symbol, 1 code overflow error).
  output logic                                 out_tuser,
  // out_tlast: set on the final result caused by one input request.
  output logic                                 out_tlast
);

  pcsd_pkg::cmd_t  cmd;
  pcsd_pkg::stat_t st;

  // The controller holds only its state register; all other storage lives in the datapath.
  pcsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the table, the accumulator, the scan pipeline and the result
  // registers, so a finished result can wait on out_tready while a new request enters.
  pcsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_op      (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready = cmd.in_ready;

`ifndef SYNTHESIS
  // Every result of the previous request must have left the pending stage before a new one.
  a_pend_empty_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !st.pend_valid)
    else $error("request accepted while a result is still pending");

  // A result is only produced when there is room to keep it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_err || cmd.emit_hit) |-> st.can_emit)
    else $error("result produced without room");

  // The accumulator never holds more than the longest code.
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.acc_len <= pcsd_pkg::MAX_LEN_L)
    else $error("accumulator length beyond maximum code length");

  // A hit emit that directly follows another hit emit must also directly follow a table match.
  a_hit_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_hit |-> ($past(st.match) || $past(cmd.emit_hit) == 1'b0))
    else $error("symbol emitted without a table match");
`endif

endmodule

`default_nettype wire
